@@ src/lgre_pkg.sv @@
// ----------------------------------------------------------------------------
// lgre_pkg
// Shared types, sizes and helpers for the life generation raster engine.
// ----------------------------------------------------------------------------
package lgre_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 64;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int CFG_DATA_W = 8;
    localparam int LINE_W     = 2;   // bit 1 middle line, bit 0 upper line

    // register indexes on the configuration port
    localparam logic CFG_BOARD_WIDTH  = 1'b0;
    localparam logic CFG_BOARD_HEIGHT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 8'd100;
    localparam logic [CFG_DATA_W-2:0] HEIGHT_RESET = 7'd50;

    typedef struct packed {
        logic shift;     // window takes a new column
        logic interior;  // emitted cell lies inside the frame border
    } t_win_ctl;

    // last column index, with the width saturated to [3, MAX_WIDTH]
    function automatic logic [COL_W-1:0] width_last(input logic [CFG_DATA_W-1:0] v);
        logic [CFG_DATA_W-1:0] c;
        begin
            if (v < 8'd3) begin
                c = 8'd3;
            end else if (v > 8'(MAX_WIDTH)) begin
                c = 8'(MAX_WIDTH);
            end else begin
                c = v;
            end
            return COL_W'(c - 8'd1);
        end
    endfunction

    // last row index, with the height saturated to [3, MAX_HEIGHT]
    function automatic logic [ROW_W-1:0] height_last(input logic [CFG_DATA_W-2:0] v);
        logic [CFG_DATA_W-2:0] c;
        begin
            if (v < 7'd3) begin
                c = 7'd3;
            end else if (v > 7'(MAX_HEIGHT)) begin
                c = 7'(MAX_HEIGHT);
            end else begin
                c = v;
            end
            return ROW_W'(c - 7'd1);
        end
    endfunction

endpackage

@@ src/lgre_line_store.sv @@
// ----------------------------------------------------------------------------
// lgre_line_store
// Upper and middle line stores in one memory, with per-entry valid bits and
// a registered read that bypasses a write to the same column.
// ----------------------------------------------------------------------------
module lgre_line_store
    import lgre_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [COL_W-1:0]  i_rd_addr,
    output logic [LINE_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [COL_W-1:0]  i_wr_addr,
    input  logic [LINE_W-1:0] i_wr_data
);

    logic [LINE_W-1:0]    r_mem [MAX_WIDTH];
    logic [MAX_WIDTH-1:0] r_valid;
    logic [LINE_W-1:0]    r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // a write at the same edge to the same column wins over the array
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else if (r_valid[i_rd_addr]) begin
                r_rd_data <= r_mem[i_rd_addr];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/lgre_window.sv @@
// ----------------------------------------------------------------------------
// lgre_window
// 3x3 neighbourhood window and the B3/S23 rule on the shifted window.
// ----------------------------------------------------------------------------
module lgre_window
    import lgre_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_win_ctl i_ctl,
    input  logic [2:0] i_col,   // bit 0 top row, bit 2 bottom row
    output logic     o_alive
);

    logic [8:0] r_win;
    logic [8:0] n_win;
    logic [3:0] count;

    always_comb begin
        n_win = {i_col, r_win[8:3]};
        count = 4'(n_win[0]) + 4'(n_win[1]) + 4'(n_win[2]) + 4'(n_win[3])
              + 4'(n_win[5]) + 4'(n_win[6]) + 4'(n_win[7]) + 4'(n_win[8]);
        o_alive = i_ctl.interior && ((count == 4'd3) || ((count == 4'd2) && n_win[4]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_ctl.shift) begin
            r_win <= n_win;
        end
    end

endmodule

@@ src/life_generation_raster_engine_top.sv @@
// ----------------------------------------------------------------------------
// life_generation_raster_engine_top
// Game of life (B3/S23) next generation over a raster stream of cells.
//
//   channel  direction  handshake                  payload
//   in       to block   i_in_valid / o_in_ready    i_cell_alive, i_frame_start
//   out      from block o_out_valid / i_out_ready  o_next_alive, o_out_column, o_out_row
//   cfg      to block   i_cfg_we                   i_cfg_index, i_cfg_data
//
// One cell a cycle while the result stage is not stalled; a result is registered
// after its input transfer (the transfer edge reads the line store into the read
// stage, and the window shift and result register load follow when it advances).
// The line store valid bits clear in the reset cycle; no clearing pass.
// A stalled output holds the result stage; the input stage keeps taking
// cells that produce no result, and otherwise waits one item deep.
// ----------------------------------------------------------------------------
module life_generation_raster_engine_top
    import lgre_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_cell_alive,
    input  logic                  i_frame_start,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_next_alive,
    output logic [COL_W-1:0]      o_out_column,
    output logic [ROW_W-1:0]      o_out_row,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration, kept as saturated last indexes
    logic [COL_W-1:0] r_wlast;
    logic [ROW_W-1:0] r_hlast;

    // position of the next cell
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    // read stage
    logic             r_s1_vld;
    logic             r_s1_cur;
    logic             r_s1_emit;
    logic             r_s1_inner;
    logic [COL_W-1:0] r_s1_x;
    logic [ROW_W-1:0] r_s1_y;

    // result register
    logic             r_out_vld;
    logic             r_out_alive;
    logic [COL_W-1:0] r_out_col;
    logic [ROW_W-1:0] r_out_row;

    logic              in_xfer;
    logic              s1_adv;
    logic [COL_W-1:0]  x;
    logic [ROW_W-1:0]  y;
    logic              border;
    logic              cur;
    logic [LINE_W-1:0] line_rd;
    logic              alive;
    t_win_ctl          win_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast <= width_last(WIDTH_RESET);
            r_hlast <= height_last(HEIGHT_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BOARD_WIDTH:  r_wlast <= width_last(i_cfg_data);
                CFG_BOARD_HEIGHT: r_hlast <= height_last(i_cfg_data[CFG_DATA_W-2:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        s1_adv     = r_s1_vld && (!r_s1_emit || !r_out_vld || i_out_ready);
        o_in_ready = !r_s1_vld || s1_adv;
        in_xfer    = i_in_valid && o_in_ready;

        x      = i_frame_start ? '0 : r_col;
        y      = i_frame_start ? '0 : r_row;
        border = (x == '0) || (y == '0) || (x >= r_wlast) || (y >= r_hlast);
        cur    = i_cell_alive && !border;

        if (x >= r_wlast) begin
            n_col = '0;
            n_row = (y >= r_hlast) ? '0 : y + ROW_W'(1);
        end else begin
            n_col = x + COL_W'(1);
            n_row = y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_xfer) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_xfer) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    // interior: the emitted cell (x-1, y-1) is off the frame border
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_cur   <= cur;
            r_s1_x     <= x;
            r_s1_y     <= y;
            r_s1_emit  <= (x != '0) && (y != '0);
            r_s1_inner <= (x >= COL_W'(2)) && (y >= ROW_W'(2))
                          && (x <= r_wlast) && (y <= r_hlast);
        end
    end

    lgre_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_xfer),
        .i_rd_addr (x),
        .o_rd_data (line_rd),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_x),
        .i_wr_data ({r_s1_cur, line_rd[1]})
    );

    assign win_ctl.shift    = s1_adv;
    assign win_ctl.interior = r_s1_inner;

    lgre_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (win_ctl),
        .i_col   ({r_s1_cur, line_rd[1], line_rd[0]}),
        .o_alive (alive)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv && r_s1_emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_emit) begin
            r_out_alive <= alive;
            r_out_col   <= r_s1_x - COL_W'(1);
            r_out_row   <= r_s1_y - ROW_W'(1);
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_next_alive = r_out_alive;
    assign o_out_column = r_out_col;
    assign o_out_row    = r_out_row;

`ifndef NO_ASSERTIONS
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_vld |-> o_in_ready)
        else $error("input not ready with empty read stage");

    a_xfer_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_s1_vld)
        else $error("accepted cell lost before read stage");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_emit && r_out_vld && !i_out_ready) |-> !s1_adv)
        else $error("result overwritten while stalled");

    a_border_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_alive) |-> ((r_out_col != '0) && (r_out_row != '0)))
        else $error("border cell emitted alive");
`endif

endmodule

@@ dv/tb_life_generation_raster_engine_top.sv @@
// ----------------------------------------------------------------------------
// tb_life_generation_raster_engine_top
// Streams raster frames of cells into the life engine and checks every
// next-generation result, in order, against a cycle-free model of the B3/S23
// rule, line stores and position counters. It starts with a hand-built blinker
// frame, then runs phases of random frames over a range of board sizes, with
// random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_life_generation_raster_engine_top;
    import lgre_pkg::*;

    localparam int RANDOM_ITEMS = 1850;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic             alive;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
    } t_cell_result;

    typedef struct packed {
        logic             alive;
        logic             fs;
        logic             typed;
        logic             exp_alive;
        logic [COL_W-1:0] exp_col;
        logic [ROW_W-1:0] exp_row;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_cell_alive = 1'b0;
    logic                  i_frame_start = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_next_alive;
    logic [COL_W-1:0]      o_out_column;
    logic [ROW_W-1:0]      o_out_row;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_index = CFG_BOARD_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    life_generation_raster_engine_top uut (.*);

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // life model state
    // ------------------------------------------------------------------
    logic [7:0]           width_reg = WIDTH_RESET;
    logic [6:0]           height_reg = HEIGHT_RESET;
    logic [MAX_WIDTH-1:0] upper_row_bits = '0;
    logic [MAX_WIDTH-1:0] middle_row_bits = '0;
    logic [8:0]           window3x3 = '0;
    int                   col_pos = 0;
    int                   row_pos = 0;
    t_cell_result         due_cells[$];

    // expectation typed into the directed table, travels with the payload
    logic                 typed_ok = 1'b0;
    t_cell_result         typed_cell = '0;

    int  mismatches = 0;
    int  quiet_cycles = 0;
    bit  steady = 1'b0;
    int  stall_left = 0;

    function automatic int eff_dim(input int v, input int hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    // advance the model by one cell; returns 1 when a result is due
    function automatic bit evolve_cell(input logic alive, input logic fs,
                                       output t_cell_result res);
        int w, h, x, y, cx, cy, cnt;
        logic cur, up, mid;
        bit emit;
        w = eff_dim(width_reg, MAX_WIDTH);
        h = eff_dim(height_reg, MAX_HEIGHT);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        x = col_pos;
        y = row_pos;
        cur = alive;
        if (x == 0 || y == 0 || x >= w - 1 || y >= h - 1) cur = 1'b0;
        up = 1'b0;
        mid = 1'b0;
        if (x < MAX_WIDTH) begin
            up = upper_row_bits[x];
            mid = middle_row_bits[x];
            upper_row_bits[x] = mid;
            middle_row_bits[x] = cur;
        end
        window3x3 = {cur, mid, up, window3x3[8:3]};
        emit = 1'b0;
        res = '0;
        if (x >= 1 && y >= 1) begin
            cx = x - 1;
            cy = y - 1;
            if (cx >= 1 && cy >= 1 && cx <= w - 2 && cy <= h - 2) begin
                cnt = 0;
                for (int b = 0; b < 9; b++) begin
                    if (b != 4 && window3x3[b]) cnt++;
                end
                res.alive = (cnt == 3) || (cnt == 2 && window3x3[4]);
            end
            res.column = cx[COL_W-1:0];
            res.row = cy[ROW_W-1:0];
            emit = 1'b1;
        end
        if (x >= w - 1) begin
            col_pos = 0;
            row_pos = (y >= h - 1) ? 0 : y + 1;
        end else begin
            col_pos = x + 1;
        end
        return emit;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", msg);
    endtask

    // ------------------------------------------------------------------
    // monitor: config writes, input transfers, result transfers
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cell_result got, want, predicted;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BOARD_WIDTH: width_reg = i_cfg_data;
                    CFG_BOARD_HEIGHT: height_reg = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                if (evolve_cell(i_cell_alive, i_frame_start, predicted))
                    due_cells.push_back(typed_ok ? typed_cell : predicted);
            end
            if (o_out_valid && i_out_ready) begin
                got = '{o_next_alive, o_out_column, o_out_row};
                if (due_cells.size() == 0) begin
                    note_mismatch($sformatf("unexpected result alive %0d col %0d row %0d",
                                            got.alive, got.column, got.row));
                end else begin
                    want = due_cells.pop_front();
                    if (got.alive !== want.alive)
                        note_mismatch($sformatf("cell (%0d,%0d) alive exp %0d got %0d",
                                                want.column, want.row, want.alive, got.alive));
                    if (got.column !== want.column)
                        note_mismatch($sformatf("column exp %0d got %0d",
                                                want.column, got.column));
                    if (got.row !== want.row)
                        note_mismatch($sformatf("row exp %0d got %0d", want.row, got.row));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure
    always @(negedge i_clk) begin
        if (steady) begin
            i_out_ready <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = idle_span();
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic push_cell(input logic alive, input logic fs, input logic typed,
                             input t_cell_result typed_res, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_cell_alive <= alive;
        i_frame_start <= fs;
        typed_ok <= typed;
        typed_cell <= typed_res;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // input idle, every result in, pipeline empty
    task automatic settle_block();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_cells.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic stream_cells(input int count);
        int frame, pos, density;
        bit noisy;
        logic alive, fs;
        frame = eff_dim(width_reg, MAX_WIDTH) * eff_dim(height_reg, MAX_HEIGHT);
        noisy = ($urandom_range(0, 4) == 0);
        density = $urandom_range(10, 70);
        pos = ($urandom_range(0, 4) == 0) ? 1 : 0;
        for (int k = 0; k < count; k++) begin
            alive = ($urandom_range(0, 99) < density);
            if (noisy)
                fs = ($urandom_range(0, 15) == 0);
            else
                fs = (pos == 0) && ($urandom_range(0, 9) != 0);
            pos = (pos + 1 == frame) ? 0 : pos + 1;
            push_cell(alive, fs, 1'b0, '0, steady ? 0 : idle_span());
        end
    endtask

    // 5x5 board, vertical blinker in column 2; live border inputs must be ignored
    t_stim_row blinker_frame [25] = '{
        '{1'b1, 1'b1, 1'b0, 1'b0, 7'd0, 6'd0},   // row 0
        '{1'b1, 1'b0, 1'b0, 1'b0, 7'd0, 6'd0},
        '{1'b1, 1'b0, 1'b0, 1'b0, 7'd0, 6'd0},
        '{1'b1, 1'b0, 1'b0, 1'b0, 7'd0, 6'd0},
        '{1'b1, 1'b0, 1'b0, 1'b0, 7'd0, 6'd0},
        '{1'b1, 1'b0, 1'b0, 1'b0, 7'd0, 6'd0},   // row 1
        '{1'b0, 1'b0, 1'b1, 1'b0, 7'd0, 6'd0},
        '{1'b1, 1'b0, 1'b1, 1'b0, 7'd1, 6'd0},
        '{1'b0, 1'b0, 1'b1, 1'b0, 7'd2, 6'd0},
        '{1'b1, 1'b0, 1'b1, 1'b0, 7'd3, 6'd0},
        '{1'b1, 1'b0, 1'b0, 1'b0, 7'd0, 6'd0},   // row 2
        '{1'b0, 1'b0, 1'b1, 1'b0, 7'd0, 6'd1},
        '{1'b1, 1'b0, 1'b0, 1'b0, 7'd0, 6'd0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 6'd0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 6'd0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 6'd0},   // row 3
        '{1'b0, 1'b0, 1'b1, 1'b0, 7'd0, 6'd2},
        '{1'b1, 1'b0, 1'b0, 1'b0, 7'd0, 6'd0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 6'd0},
        '{1'b1, 1'b0, 1'b0, 1'b0, 7'd0, 6'd0},
        '{1'b1, 1'b0, 1'b0, 1'b0, 7'd0, 6'd0},   // row 4, bottom border
        '{1'b1, 1'b0, 1'b1, 1'b0, 7'd0, 6'd3},
        '{1'b1, 1'b0, 1'b0, 1'b0, 7'd0, 6'd0},
        '{1'b1, 1'b0, 1'b0, 1'b0, 7'd0, 6'd0},
        '{1'b1, 1'b0, 1'b0, 1'b0, 7'd0, 6'd0}
    };

    // board size extremes, raw register values incl. out of range
    int extreme_w [8] = '{3, 128, 3, 0, 255, 2, 129, 200};
    int extreme_h [8] = '{3, 3, 64, 0, 200, 1, 65, 127};

    initial begin
        int sent, n, wd, hd;
        bit set_w, set_h;
        t_stim_row r;
        wait (i_rst_n);
        write_reg(CFG_BOARD_WIDTH, 8'd5);
        write_reg(CFG_BOARD_HEIGHT, 8'd5);
        foreach (blinker_frame[i]) begin
            r = blinker_frame[i];
            push_cell(r.alive, r.fs, r.typed, '{r.exp_alive, r.exp_col, r.exp_row},
                      idle_span());
        end

        sent = 0;
        for (int p = 0; sent < RANDOM_ITEMS; p++) begin
            set_w = 1'b1;
            set_h = 1'b1;
            if (p < 8) begin
                wd = extreme_w[p];
                hd = extreme_h[p];
            end else begin
                wd = ($urandom_range(0, 9) < 6) ? $urandom_range(3, 12) : $urandom_range(0, 255);
                hd = ($urandom_range(0, 9) < 6) ? $urandom_range(3, 10) : $urandom_range(0, 255);
                case ($urandom_range(0, 9))
                    0: set_w = 1'b0;
                    1: set_h = 1'b0;
                    default: ;
                endcase
            end
            settle_block();
            steady = ($urandom_range(0, 3) == 0);
            if (set_w) write_reg(CFG_BOARD_WIDTH, wd[7:0]);
            if (set_h) write_reg(CFG_BOARD_HEIGHT, hd[7:0]);
            n = eff_dim(width_reg, MAX_WIDTH) * eff_dim(height_reg, MAX_HEIGHT)
                * $urandom_range(1, 2) + $urandom_range(0, 4);
            // big boards only get a partial frame
            if (n > 420) n = $urandom_range(300, 420);
            // last phase stops at the item budget
            if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
            stream_cells(n);
            sent += n;
        end

        settle_block();
        steady = 1'b0;
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && due_cells.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
